// ===== rtl/dpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Directory path resolver package
// Shared item types, table row layout, character codes and sequencer states.
// ----------------------------------------------------------------------------
package dpr_pkg;

    localparam int ENTRY_BYTES = 16;
    localparam int NAME_CHARS  = 15;
    localparam int LEN_W       = 4;

    localparam logic [7:0] ROOT_DIR   = 8'hFF;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] END_CHAR   = 8'h00;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PATH  = 1'b1;

    // byte 0 is the parent index, bytes 1..15 the name
    typedef logic [ENTRY_BYTES-1:0][7:0] t_row;
    typedef logic [NAME_CHARS-1:0][7:0]  t_name;

    typedef struct packed {
        logic       action;
        logic [8:0] table_addr;
        logic [7:0] data_byte;
        logic       path_start;
        logic [7:0] start_dir;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [7:0] dir_index;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PAR_RD,
        S_PAR_LD,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/dpr_table_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Directory table memory
// One row per entry, byte-lane writes, one registered row read per cycle.
// ----------------------------------------------------------------------------
module dpr_table_ram #(
    parameter int  ROWS  = 32,
    localparam int ROW_W = $clog2(ROWS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ROW_W-1:0]  i_wrow,
    input  wire logic [3:0]        i_wlane,
    input  wire logic [7:0]        i_wdata,
    input  wire logic [ROW_W-1:0]  i_raddr,
    output dpr_pkg::t_row          o_rdata
);

    dpr_pkg::t_row r_mem [ROWS];
    dpr_pkg::t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wrow][i_wlane] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/dpr_entry_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Entry comparator
// Checks one table row against the current directory and collected component.
// ----------------------------------------------------------------------------
module dpr_entry_match (
    input  wire dpr_pkg::t_row             i_row,
    input  wire dpr_pkg::t_name            i_name,
    input  wire logic [dpr_pkg::LEN_W-1:0] i_len,
    input  wire logic [7:0]                i_cur_dir,
    output logic                           o_hit
);

    logic w_ok;

    // chars below len must match; entry must end right at len unless full
    always_comb begin
        w_ok = 1'b1;
        for (int i = 0; i < dpr_pkg::NAME_CHARS; i++) begin
            if (dpr_pkg::LEN_W'(i) < i_len) begin
                if (i_row[i+1] != i_name[i]) begin
                    w_ok = 1'b0;
                end
            end else if (dpr_pkg::LEN_W'(i) == i_len) begin
                if (i_row[i+1] != dpr_pkg::END_CHAR) begin
                    w_ok = 1'b0;
                end
            end
        end
    end

    assign o_hit = w_ok && (i_len != '0) && (i_row[0] == i_cur_dir);

endmodule
`default_nettype wire

// ===== rtl/directory_path_resolver_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A table write or a plain path character is taken while idle. A '/' or end
// of path runs a lookup: a name scan (one entry compare per cycle from the
// table RAM port), or S_PAR_RD and, unless at root or out of range, S_PAR_LD
// for "..", then on path end the result register load in S_EMIT, which waits
// for a free output slot. Throughput: one item at a time; not ready until idle.
// Reset (synchronous, active low) sets current dir to root, clears state.
// ----------------------------------------------------------------------------
// Directory path resolver core
// Walks a slash-separated path through a loaded directory table.
// ----------------------------------------------------------------------------
module directory_path_resolver_core #(
    parameter int TABLE_BYTES = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire dpr_pkg::t_in_item i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output dpr_pkg::t_out_item o_out_data
);

    localparam int ENTRY_COUNT = TABLE_BYTES / dpr_pkg::ENTRY_BYTES;
    localparam int IDX_W       = $clog2(ENTRY_COUNT);
    localparam int CNT_W       = IDX_W + 1;

    dpr_pkg::t_state r_state, n_state;

    logic [7:0]                r_cur;
    logic [dpr_pkg::LEN_W-1:0] r_len;
    logic                      r_failed;
    logic                      r_end;
    dpr_pkg::t_name            r_name;
    logic [CNT_W-1:0]          r_idx;
    logic [IDX_W-1:0]          r_cmp_idx;
    logic                      r_cmp_valid;
    logic                      r_out_valid;
    dpr_pkg::t_out_item        r_out_data;

    logic                      w_accept;
    logic [7:0]                w_cur_eff;
    logic [dpr_pkg::LEN_W-1:0] w_len_eff;
    logic                      w_fail_eff;
    logic                      w_is_end;
    logic                      w_is_sep;
    logic                      w_store;
    logic                      w_dotdot;
    logic                      w_ram_we;
    logic [IDX_W-1:0]          w_raddr;
    dpr_pkg::t_row             w_rdata;
    logic                      w_hit;
    logic                      w_scan_hit;
    logic                      w_scan_last;
    logic                      w_scan_issue;
    logic                      w_par_root;
    logic                      w_par_oob;
    logic                      w_slot_free;
    logic                      w_out_load;
    dpr_pkg::t_state           w_fin_state;

    // ---- input decode ----
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cur_eff  = i_in_data.path_start ? i_in_data.start_dir : r_cur;
    assign w_len_eff  = i_in_data.path_start ? '0 : r_len;
    assign w_fail_eff = i_in_data.path_start ? 1'b0 : r_failed;
    assign w_is_end   = (i_in_data.data_byte == dpr_pkg::END_CHAR);
    assign w_is_sep   = w_is_end || (i_in_data.data_byte == dpr_pkg::SLASH_CHAR);
    assign w_store    = w_accept && (i_in_data.action == dpr_pkg::ACT_PATH) && !w_is_sep
                        && !w_fail_eff
                        && (w_len_eff < dpr_pkg::LEN_W'(dpr_pkg::NAME_CHARS));
    assign w_dotdot   = (w_len_eff == dpr_pkg::LEN_W'(2))
                        && (r_name[0] == dpr_pkg::DOT_CHAR)
                        && (r_name[1] == dpr_pkg::DOT_CHAR);
    assign w_ram_we   = w_accept && (i_in_data.action == dpr_pkg::ACT_WRITE)
                        && (32'(i_in_data.table_addr) < TABLE_BYTES);

    // ---- lookup status ----
    assign w_scan_issue = (r_idx < CNT_W'(ENTRY_COUNT));
    assign w_scan_hit   = r_cmp_valid && w_hit;
    assign w_scan_last  = r_cmp_valid && (r_cmp_idx == IDX_W'(ENTRY_COUNT - 1));
    assign w_par_root   = (r_cur == dpr_pkg::ROOT_DIR);
    assign w_par_oob    = (32'(r_cur) >= ENTRY_COUNT);
    assign w_slot_free  = !r_out_valid || i_out_ready;
    assign w_fin_state  = r_end ? dpr_pkg::S_EMIT : dpr_pkg::S_IDLE;

    dpr_table_ram #(
        .ROWS (ENTRY_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_wrow  (IDX_W'(i_in_data.table_addr >> 4)),
        .i_wlane (i_in_data.table_addr[3:0]),
        .i_wdata (i_in_data.data_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dpr_entry_match u_match (
        .i_row     (w_rdata),
        .i_name    (r_name),
        .i_len     (r_len),
        .i_cur_dir (r_cur),
        .o_hit     (w_hit)
    );

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            dpr_pkg::S_IDLE: begin
                if (w_accept && (i_in_data.action == dpr_pkg::ACT_PATH) && w_is_sep) begin
                    if (w_fail_eff) begin
                        n_state = w_is_end ? dpr_pkg::S_EMIT : dpr_pkg::S_IDLE;
                    end else if (w_dotdot) begin
                        n_state = dpr_pkg::S_PAR_RD;
                    end else begin
                        n_state = dpr_pkg::S_SCAN;
                    end
                end
            end
            dpr_pkg::S_SCAN: begin
                if (w_scan_hit || w_scan_last) begin
                    n_state = w_fin_state;
                end
            end
            dpr_pkg::S_PAR_RD: begin
                if (w_par_root || w_par_oob) begin
                    n_state = w_fin_state;
                end else begin
                    n_state = dpr_pkg::S_PAR_LD;
                end
            end
            dpr_pkg::S_PAR_LD: begin
                n_state = w_fin_state;
            end
            dpr_pkg::S_EMIT: begin
                if (w_slot_free) begin
                    n_state = dpr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dpr_pkg::S_IDLE;
            end
        endcase
    end

    // ---- state outputs ----
    always_comb begin
        o_in_ready = 1'b0;
        w_raddr    = IDX_W'(r_cur);
        w_out_load = 1'b0;
        case (r_state)
            dpr_pkg::S_IDLE:   o_in_ready = 1'b1;
            dpr_pkg::S_SCAN:   w_raddr    = r_idx[IDX_W-1:0];
            dpr_pkg::S_PAR_RD: w_raddr    = IDX_W'(r_cur);
            dpr_pkg::S_PAR_LD: w_raddr    = IDX_W'(r_cur);
            dpr_pkg::S_EMIT:   w_out_load = w_slot_free;
            default:           o_in_ready = 1'b0;
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpr_pkg::S_IDLE;
            r_cur       <= dpr_pkg::ROOT_DIR;
            r_len       <= '0;
            r_failed    <= 1'b0;
            r_end       <= 1'b0;
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out_valid && i_out_ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                dpr_pkg::S_IDLE: begin
                    if (w_accept && (i_in_data.action == dpr_pkg::ACT_PATH)) begin
                        r_cur    <= w_cur_eff;
                        r_failed <= w_fail_eff;
                        if (w_store) begin
                            r_len <= w_len_eff + 1'b1;
                        end else if (w_is_sep && w_fail_eff) begin
                            r_len <= '0;
                        end else begin
                            r_len <= w_len_eff;
                        end
                        if (w_is_sep) begin
                            r_end       <= w_is_end;
                            r_idx       <= '0;
                            r_cmp_valid <= 1'b0;
                        end
                    end
                end
                dpr_pkg::S_SCAN: begin
                    // read entry r_idx while comparing the one read last cycle
                    r_cmp_valid <= w_scan_issue;
                    r_cmp_idx   <= r_idx[IDX_W-1:0];
                    if (w_scan_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (w_scan_hit) begin
                        r_cur <= 8'(r_cmp_idx);
                        r_len <= '0;
                    end else if (w_scan_last) begin
                        r_failed <= 1'b1;
                        r_len    <= '0;
                    end
                end
                dpr_pkg::S_PAR_RD: begin
                    if (w_par_root) begin
                        r_len <= '0;
                    end else if (w_par_oob) begin
                        r_failed <= 1'b1;
                        r_len    <= '0;
                    end
                end
                dpr_pkg::S_PAR_LD: begin
                    r_cur <= w_rdata[0];
                    r_len <= '0;
                end
                dpr_pkg::S_EMIT: begin
                    if (w_out_load) begin
                        r_out_valid <= 1'b1;
                        r_failed    <= 1'b0;
                    end
                end
                default: begin
                    r_len <= '0;
                end
            endcase
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_name[w_len_eff] <= i_in_data.data_byte;
        end
        if (w_out_load) begin
            r_out_data.found     <= !r_failed;
            r_out_data.dir_index <= r_failed ? 8'h00 : r_cur;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---- assertions ----
    a_scan_no_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dpr_pkg::S_SCAN) |-> !r_failed)
        else $error("lookup running on a failed path");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dpr_pkg::S_SCAN) |-> (r_idx <= CNT_W'(ENTRY_COUNT)))
        else $error("scan index past last entry");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |-> (o_out_data.dir_index == 8'h00))
        else $error("not-found item carries a directory");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_out_valid && !r_failed && (r_state == dpr_pkg::S_IDLE)))
        else $error("result load did not finish the path");

    a_load_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && o_out_valid) |-> i_out_ready)
        else $error("result overwritten before taken");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directory path resolver testbench
// Loads the whole directory table, then sends directed and random paths
// through the valid/ready channels. A path walker predicts the lookups,
// typed directed rows fix their own; all compared in order in idle phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_BYTES  = 512;
    localparam int ENTRY_COUNT  = TABLE_BYTES / dpr_pkg::ENTRY_BYTES;
    localparam int ITEM_TARGET  = 1700;
    localparam int PHASE_ITEMS  = 140;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        bit         with_start;
        logic [7:0] from_dir;
        string      path;
        bit         typed;
        bit         found;
        logic [7:0] dir;
    } t_path_case;

    // rows with typed results are obvious from the table contents
    t_path_case path_cases[14] = '{
        '{1'b1, dpr_pkg::ROOT_DIR, "",                  1'b1, 1'b0, 8'h00},
        '{1'b1, dpr_pkg::ROOT_DIR, "..",                1'b1, 1'b1, dpr_pkg::ROOT_DIR},
        '{1'b1, 8'd100,            "..",                1'b1, 1'b0, 8'h00},
        '{1'b1, dpr_pkg::ROOT_DIR, "a",                 1'b1, 1'b1, 8'd0},
        '{1'b0, 8'd0,              "b",                 1'b0, 1'b0, 8'h00},
        '{1'b1, dpr_pkg::ROOT_DIR, "a/b/c",             1'b0, 1'b0, 8'h00},
        '{1'b1, dpr_pkg::ROOT_DIR, "abcdefghijklmnopq", 1'b0, 1'b0, 8'h00},
        '{1'b1, dpr_pkg::ROOT_DIR, "ab",                1'b0, 1'b0, 8'h00},
        '{1'b1, dpr_pkg::ROOT_DIR, "a//b",              1'b1, 1'b0, 8'h00},
        '{1'b1, dpr_pkg::ROOT_DIR, "a/",                1'b1, 1'b0, 8'h00},
        '{1'b0, 8'd0,              "zz",                1'b0, 1'b0, 8'h00},
        '{1'b1, 8'd0,              "zz/..",             1'b0, 1'b0, 8'h00},
        '{1'b1, dpr_pkg::ROOT_DIR, "\377\001",          1'b0, 1'b0, 8'h00},
        '{1'b1, 8'd3,              "../../..",          1'b0, 1'b0, 8'h00}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    dpr_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_ready;
    dpr_pkg::t_out_item out_data;

    // path walker state
    logic [7:0] dir_mem[TABLE_BYTES];
    logic [7:0] comp_buf[dpr_pkg::NAME_CHARS] = '{default: 8'h00};
    int         comp_len    = 0;
    logic [7:0] walk_dir    = dpr_pkg::ROOT_DIR;
    bit         walk_failed = 1'b0;

    logic [7:0]         table_image[TABLE_BYTES];
    logic [7:0]         comp_chars[$];
    dpr_pkg::t_out_item pending_lookups[$];
    int                 mismatch_count    = 0;
    int                 items_sent        = 0;
    int                 gap_pct           = 0;
    int                 stall_pct         = 0;
    bit                 interleave_writes = 1'b0;

    directory_path_resolver_core #(
        .TABLE_BYTES(TABLE_BYTES)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always #5 clk = ~clk;

    function automatic bit entry_matches(int e);
        int base;
        int i;
        base = e * dpr_pkg::ENTRY_BYTES + 1;
        i = 0;
        while (i < dpr_pkg::NAME_CHARS && i < comp_len && dir_mem[base + i] != 8'h00) begin
            if (dir_mem[base + i] != comp_buf[i]) return 1'b0;
            i++;
        end
        if (i == 0) return 1'b0;
        if (i == dpr_pkg::NAME_CHARS) return 1'b1;
        return dir_mem[base + i] == ((i < comp_len) ? comp_buf[i] : 8'h00);
    endfunction

    function automatic void resolve_component();
        if (comp_len == 2 && comp_buf[0] == dpr_pkg::DOT_CHAR
            && comp_buf[1] == dpr_pkg::DOT_CHAR) begin
            if (walk_dir == dpr_pkg::ROOT_DIR) return;
            if (int'(walk_dir) >= ENTRY_COUNT) begin
                walk_failed = 1'b1;
                return;
            end
            walk_dir = dir_mem[int'(walk_dir) * dpr_pkg::ENTRY_BYTES];
            return;
        end
        for (int e = 0; e < ENTRY_COUNT; e++) begin
            if (dir_mem[e * dpr_pkg::ENTRY_BYTES] == walk_dir && entry_matches(e)) begin
                walk_dir = 8'(e);
                return;
            end
        end
        walk_failed = 1'b1;
    endfunction

    function automatic bit predict_resolution(dpr_pkg::t_in_item it,
                                              output dpr_pkg::t_out_item res);
        res = '0;
        if (it.action == dpr_pkg::ACT_WRITE) begin
            if (int'(it.table_addr) < TABLE_BYTES) dir_mem[it.table_addr] = it.data_byte;
            return 1'b0;
        end
        if (it.path_start) begin
            walk_dir    = it.start_dir;
            comp_len    = 0;
            walk_failed = 1'b0;
        end
        if (it.data_byte != dpr_pkg::END_CHAR && it.data_byte != dpr_pkg::SLASH_CHAR) begin
            if (!walk_failed && comp_len < dpr_pkg::NAME_CHARS) begin
                comp_buf[comp_len] = it.data_byte;
                comp_len++;
            end
            return 1'b0;
        end
        if (!walk_failed) resolve_component();
        comp_len = 0;
        if (it.data_byte == dpr_pkg::SLASH_CHAR) return 1'b0;
        res.found     = !walk_failed;
        res.dir_index = walk_failed ? 8'h00 : walk_dir;
        walk_failed   = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_result(dpr_pkg::t_out_item got);
        dpr_pkg::t_out_item want;
        if (pending_lookups.size() == 0) begin
            report_mismatch($sformatf("unexpected result found=%0b dir=%0d",
                                      got.found, got.dir_index));
            return;
        end
        want = pending_lookups.pop_front();
        if (got.found !== want.found)
            report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
        if (got.dir_index !== want.dir_index)
            report_mismatch($sformatf("dir_index %0d, want %0d",
                                      got.dir_index, want.dir_index));
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) check_result(out_data);
        out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    task automatic push_item(dpr_pkg::t_in_item it, bit fixed = 1'b0,
                             dpr_pkg::t_out_item fixed_res = '0);
        dpr_pkg::t_out_item res;
        bit                 has_result;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_ready !== 1'b1);
        has_result = predict_resolution(it, res);
        if (has_result) pending_lookups.push_back(fixed ? fixed_res : res);
        items_sent++;
    endtask

    task automatic send_write(int addr, logic [7:0] data);
        dpr_pkg::t_in_item it;
        it.action     = dpr_pkg::ACT_WRITE;
        it.table_addr = 9'(addr);
        it.data_byte  = data;
        it.path_start = 1'($urandom_range(1));
        it.start_dir  = 8'($urandom_range(255));
        push_item(it);
    endtask

    function automatic logic [7:0] name_char();
        string alphabet;
        alphabet = "abcz.";
        return alphabet[$urandom_range(alphabet.len() - 1)];
    endfunction

    task automatic random_write();
        int         addr;
        logic [7:0] data;
        int         r;
        addr = $urandom_range(TABLE_BYTES - 1);
        r = $urandom_range(99);
        if (addr % dpr_pkg::ENTRY_BYTES == 0)
            data = (r < 50) ? dpr_pkg::ROOT_DIR :
                   (r < 95) ? 8'($urandom_range(ENTRY_COUNT - 1)) : 8'($urandom_range(255));
        else
            data = (r < 50) ? name_char() : (r < 70) ? 8'h00 : 8'($urandom_range(255));
        send_write(addr, data);
    endtask

    task automatic send_char(logic [7:0] ch, bit st, logic [7:0] sdir,
                             bit fixed = 1'b0, dpr_pkg::t_out_item fixed_res = '0);
        dpr_pkg::t_in_item it;
        if (interleave_writes && $urandom_range(99) < 4) random_write();
        it.action     = dpr_pkg::ACT_PATH;
        it.table_addr = 9'($urandom_range(TABLE_BYTES - 1));
        it.data_byte  = ch;
        it.path_start = st;
        it.start_dir  = st ? sdir : 8'($urandom_range(255));
        push_item(it, fixed, fixed_res);
    endtask

    task automatic set_idle_mode(int m);
        case (m)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 46; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 46; end
            default: begin gap_pct = 26; stall_pct = 26; end
        endcase
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_lookups.size() != 0);
    endtask

    task automatic set_entry(int idx, logic [7:0] parent, string nm);
        table_image[idx * dpr_pkg::ENTRY_BYTES] = parent;
        for (int i = 0; i < dpr_pkg::NAME_CHARS; i++)
            table_image[idx * dpr_pkg::ENTRY_BYTES + 1 + i] = (i < nm.len()) ? nm[i] : 8'h00;
    endtask

    task automatic build_table_image();
        int len;
        int base;
        set_entry(0, dpr_pkg::ROOT_DIR, "a");
        set_entry(1, 8'd0,              "b");
        set_entry(2, dpr_pkg::ROOT_DIR, "abcdefghijklmno");
        set_entry(3, 8'd1,              "c");
        set_entry(4, dpr_pkg::ROOT_DIR, "ab");
        set_entry(5, 8'd0,              "b");      // shadowed by entry 1
        set_entry(6, dpr_pkg::ROOT_DIR, "\377\001");
        set_entry(7, 8'd0,              "zz");
        for (int e = 8; e < ENTRY_COUNT; e++) begin
            base = e * dpr_pkg::ENTRY_BYTES;
            case ($urandom_range(9))
                0, 1, 2, 3: table_image[base] = dpr_pkg::ROOT_DIR;
                9:          table_image[base] = 8'($urandom_range(255));
                default:    table_image[base] = 8'($urandom_range(ENTRY_COUNT - 1));
            endcase
            len = ($urandom_range(9) == 0) ? dpr_pkg::NAME_CHARS : $urandom_range(3, 1);
            for (int i = 0; i < dpr_pkg::NAME_CHARS; i++)
                table_image[base + 1 + i] = (i < len) ? name_char() :
                                            (i == len) ? 8'h00 : 8'($urandom_range(255));
        end
    endtask

    // mostly a child name of the given directory, so walks go deep
    task automatic build_component(logic [7:0] from_dir);
        int kids[$];
        int pick;
        int k;
        comp_chars.delete();
        for (int e = 0; e < ENTRY_COUNT; e++)
            if (dir_mem[e * dpr_pkg::ENTRY_BYTES] == from_dir
                && dir_mem[e * dpr_pkg::ENTRY_BYTES + 1] != 8'h00)
                kids.push_back(e);
        pick = $urandom_range(99);
        if (pick < 12) begin
            comp_chars = '{dpr_pkg::DOT_CHAR, dpr_pkg::DOT_CHAR};
        end else if (pick < 82 && kids.size() > 0) begin
            k = kids[$urandom_range(kids.size() - 1)];
            for (int i = 1; i < dpr_pkg::ENTRY_BYTES
                 && dir_mem[k * dpr_pkg::ENTRY_BYTES + i] != 8'h00; i++)
                comp_chars.push_back(dir_mem[k * dpr_pkg::ENTRY_BYTES + i]);
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(4, 1)) comp_chars.push_back(name_char());
        end else begin
            repeat ($urandom_range(3)) comp_chars.push_back(name_char());
        end
    endtask

    task automatic run_walk(int start_pct);
        bit         start_pending;
        logic [7:0] sdir;
        int         ncomp;
        int         r;
        start_pending = ($urandom_range(99) < start_pct);
        r = $urandom_range(99);
        sdir = (r < 70) ? dpr_pkg::ROOT_DIR :
               (r < 95) ? 8'($urandom_range(ENTRY_COUNT - 1)) : 8'($urandom_range(255));
        ncomp = $urandom_range(4, 1);
        for (int c = 0; c < ncomp; c++) begin
            build_component((c == 0 && start_pending) ? sdir : walk_dir);
            foreach (comp_chars[i]) begin
                send_char(comp_chars[i], start_pending, sdir);
                start_pending = 1'b0;
            end
            if (c != ncomp - 1) begin
                send_char(dpr_pkg::SLASH_CHAR, start_pending, sdir);
                start_pending = 1'b0;
            end
        end
        send_char(dpr_pkg::END_CHAR, start_pending, sdir);
    endtask

    task automatic run_noise();
        repeat ($urandom_range(6, 1))
            send_char(8'($urandom_range(255)), $urandom_range(3) == 0, 8'($urandom_range(255)));
        if ($urandom_range(99) < 80) send_char(dpr_pkg::END_CHAR, 1'b0, dpr_pkg::ROOT_DIR);
    endtask

    task automatic run_directed();
        t_path_case         pc;
        bit                 start_pending;
        dpr_pkg::t_out_item want;
        foreach (path_cases[k]) begin
            pc = path_cases[k];
            start_pending = pc.with_start;
            for (int i = 0; i < pc.path.len(); i++) begin
                send_char(pc.path[i], start_pending, pc.from_dir);
                start_pending = 1'b0;
            end
            want.found     = pc.found;
            want.dir_index = pc.dir;
            send_char(dpr_pkg::END_CHAR, start_pending, pc.from_dir, pc.typed, want);
        end
    endtask

    initial begin
        int mode;
        int next_switch;
        int r;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        set_idle_mode(0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // every table byte is written before the first lookup
        set_idle_mode(3);
        build_table_image();
        for (int a = 0; a < TABLE_BYTES; a++) send_write(a, table_image[a]);
        drain_results();

        set_idle_mode(0);
        run_directed();
        drain_results();

        interleave_writes = 1'b1;
        mode = 1;
        set_idle_mode(mode);
        next_switch = items_sent + PHASE_ITEMS;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= next_switch) begin
                drain_results();
                mode = (mode + 1) % 4;
                set_idle_mode(mode);
                next_switch = items_sent + PHASE_ITEMS;
            end
            r = $urandom_range(99);
            if (r < 65)      run_walk(85);
            else if (r < 75) repeat ($urandom_range(4, 1)) random_write();
            else if (r < 87) run_walk(0);
            else             run_noise();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dpr_pkg.sv
rtl/dpr_table_ram.sv
rtl/dpr_entry_match.sv
rtl/directory_path_resolver_core.sv
dv/testbench.sv
